/* rtl/tcrs_pkg.sv */
package tcrs_pkg;

  // field widths of the item channels
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned DUR_W   = 47;
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned FRAC_W  = 17;
  localparam int unsigned CIDX_W  = 10;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned STEP_W  = 24;
  localparam int unsigned PROD_W  = DUR_W + FRAC_W;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [0:0]  REG_TICK_STEP = 1'b0;
  localparam logic [STEP_W-1:0] TICK_STEP_RST = STEP_W'(125000);

  // function codes
  localparam logic [FUNC_W-1:0] FN_LOAD     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SEEK_T   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SEEK_POS = 3'd2;
  localparam logic [FUNC_W-1:0] FN_TICK     = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SET_TIME = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_DONE   = 2'd1;
  localparam logic [STAT_W-1:0] ST_REJECT = 2'd2;

  localparam logic [FRAC_W-1:0] FRAC_FULL = 17'h10000;

  typedef struct packed {
    logic                     is_status;
    logic [CIDX_W-1:0]        cue_index;
    logic signed [TIME_W-1:0] pts_or_pcr;
    logic [DUR_W-1:0]         duration;
    logic                     has_duration;
    logic                     continued;
    logic                     discontinuity;
    logic                     pcr_valid;
    logic signed [TIME_W-1:0] next_time;
    logic signed [TIME_W-1:0] total_length;
    logic [STAT_W-1:0]        status_code;
    logic                     last;
  } out_item_t;

endpackage

/* rtl/tcrs_if.sv */
interface tcrs_in_if;
  import tcrs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [TIME_W-1:0] time_value;
  logic signed [TIME_W-1:0] cue_stop;
  logic [FRAC_W-1:0]        fraction;

  modport source (output valid, func, time_value, cue_stop, fraction, input ready);
  modport sink (input valid, func, time_value, cue_stop, fraction, output ready);
endinterface

interface tcrs_out_if;
  import tcrs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     is_status;
  logic [CIDX_W-1:0]        cue_index;
  logic signed [TIME_W-1:0] pts_or_pcr;
  logic [DUR_W-1:0]         duration;
  logic                     has_duration;
  logic                     continued;
  logic                     discontinuity;
  logic                     pcr_valid;
  logic signed [TIME_W-1:0] next_time;
  logic signed [TIME_W-1:0] total_length;
  logic [STAT_W-1:0]        status_code;
  logic                     last;

  modport source (output valid, is_status, cue_index, pts_or_pcr, duration, has_duration,
                  continued, discontinuity, pcr_valid, next_time, total_length,
                  status_code, last, input ready);
  modport sink (input valid, is_status, cue_index, pts_or_pcr, duration, has_duration,
                continued, discontinuity, pcr_valid, next_time, total_length,
                status_code, last, output ready);
endinterface

/* rtl/tcrs_cue_mem.sv */
module tcrs_cue_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [AW-1:0]                     wr_addr,
  input  logic [2*tcrs_pkg::TIME_W-1:0]     wr_data,
  input  logic                              rd_en,
  input  logic [AW-1:0]                     rd_addr,
  output logic [2*tcrs_pkg::TIME_W-1:0]     rd_data
);
  import tcrs_pkg::*;

  // {start, stop} per cue
  logic [2*TIME_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/tcrs_cfg.sv */
module tcrs_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tcrs_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [tcrs_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [tcrs_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [tcrs_pkg::STEP_W-1:0]         tick_step
);
  import tcrs_pkg::*;

  logic [STEP_W-1:0] tick_step_r;
  logic              wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_TICK_STEP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_step_r <= TICK_STEP_RST;
    end else if (wr_hit) begin
      tick_step_r <= pwdata[STEP_W-1:0];
    end
  end

  // read back; addresses with bit 2 set read zero
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TICK_STEP) begin
      prdata = CFG_DATA_W'(tick_step_r);
    end
  end

  assign tick_step = tick_step_r;

endmodule

/* rtl/tcrs_ctrl.sv */
module tcrs_ctrl #(
  parameter int unsigned CUE_DEPTH   = 1024,
  parameter int unsigned MAX_RELEASE = 32,
  parameter int unsigned IDX_W       = 10,
  parameter int unsigned CNT_W       = 11
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [tcrs_pkg::FUNC_W-1:0]           in_func,
  input  logic signed [tcrs_pkg::TIME_W-1:0]    in_time_value,
  input  logic signed [tcrs_pkg::TIME_W-1:0]    in_cue_stop,
  input  logic [tcrs_pkg::FRAC_W-1:0]           in_fraction,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output tcrs_pkg::out_item_t                   out_item,
  input  logic [tcrs_pkg::STEP_W-1:0]           tick_step,
  output logic                                  mem_wr_en,
  output logic [IDX_W-1:0]                      mem_wr_addr,
  output logic [2*tcrs_pkg::TIME_W-1:0]         mem_wr_data,
  output logic                                  mem_rd_en,
  output logic [IDX_W-1:0]                      mem_rd_addr,
  input  logic [2*tcrs_pkg::TIME_W-1:0]         mem_rd_data
);
  import tcrs_pkg::*;

  localparam int unsigned EX_W = $clog2(MAX_RELEASE + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_SCALE, S_SRCH_RD, S_SRCH_CMP, S_SEEK_RD, S_SEEK_SET,
    S_TICK_RD, S_TICK_CHK, S_TICK_END, S_STATUS
  } state_t;

  state_t                   state_r;
  logic [FUNC_W-1:0]        func_r;
  logic signed [TIME_W-1:0] tv_r;
  logic signed [TIME_W-1:0] stop_r;
  logic [FRAC_W-1:0]        frac_r;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         cur_r;
  logic signed [TIME_W-1:0] release_r;
  logic signed [TIME_W-1:0] len_r;
  logic                     slave_r;
  logic                     disc_r;
  logic [CNT_W-1:0]         lo_r;
  logic [CNT_W-1:0]         hi_r;
  logic [CNT_W-1:0]         mid_r;
  logic signed [TIME_W-1:0] seek_t_r;
  logic [PROD_W-1:0]        prod_r;
  logic signed [TIME_W-1:0] barrier_r;
  logic [EX_W-1:0]          exam_r;
  logic [STAT_W-1:0]        status_r;
  logic                     pcr_valid_r;
  logic                     out_valid_r;
  out_item_t                out_r;

  logic                     slot_free;
  logic [CNT_W-1:0]         mid_nxt;
  logic signed [TIME_W-1:0] rd_start;
  logic signed [TIME_W-1:0] rd_stop;
  logic [DUR_W-1:0]         len_pos;
  logic [FRAC_W-1:0]        frac_sat;
  logic                     hd;
  logic                     tick_more;
  logic                     cue_fire;
  logic                     stat_fire;
  out_item_t                cue_item;
  out_item_t                stat_item;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign mid_nxt   = lo_r + ((hi_r - lo_r) >> 1);
  assign rd_start  = mem_rd_data[2*TIME_W-1:TIME_W];
  assign rd_stop   = mem_rd_data[TIME_W-1:0];
  assign len_pos   = len_r[TIME_W-1] ? '0 : len_r[DUR_W-1:0];
  assign frac_sat  = (frac_r > FRAC_FULL) ? FRAC_FULL : frac_r;
  assign hd        = !rd_stop[TIME_W-1] && (rd_stop >= rd_start);
  assign tick_more = (cur_r < count_r) && (exam_r < EX_W'(MAX_RELEASE));

  // an item goes out this cycle
  assign cue_fire  = (state_r == S_TICK_CHK) && !(rd_start > barrier_r) &&
                     !rd_start[TIME_W-1] && slot_free;
  assign stat_fire = (state_r == S_STATUS) && slot_free;

  // outgoing cue and status items
  always_comb begin
    cue_item               = '0;
    cue_item.cue_index     = CIDX_W'(cur_r);
    cue_item.pts_or_pcr    = rd_start;
    cue_item.duration      = hd ? DUR_W'(rd_stop - rd_start) : '0;
    cue_item.has_duration  = hd;
    cue_item.continued     = (cur_r != '0);
    cue_item.discontinuity = disc_r;
    cue_item.next_time     = release_r;
    cue_item.total_length  = len_r;

    stat_item              = '0;
    stat_item.is_status    = 1'b1;
    stat_item.pts_or_pcr   = pcr_valid_r ? barrier_r : '0;
    stat_item.pcr_valid    = pcr_valid_r;
    stat_item.next_time    = release_r;
    stat_item.total_length = len_r;
    stat_item.status_code  = status_r;
    stat_item.last         = 1'b1;
  end

  // memory requests
  always_comb begin
    mem_wr_en   = (state_r == S_EXEC) && (func_r == FN_LOAD) &&
                  (count_r < CNT_W'(CUE_DEPTH));
    mem_wr_addr = count_r[IDX_W-1:0];
    mem_wr_data = {tv_r, stop_r};
    mem_rd_en   = 1'b0;
    mem_rd_addr = cur_r[IDX_W-1:0];
    case (state_r)
      S_SRCH_RD: begin
        mem_rd_en   = (lo_r < hi_r);
        mem_rd_addr = mid_nxt[IDX_W-1:0];
      end
      S_SEEK_RD: begin
        mem_rd_en   = (lo_r < count_r);
        mem_rd_addr = lo_r[IDX_W-1:0];
      end
      S_TICK_RD: begin
        mem_rd_en   = tick_more;
      end
      default: ;
    endcase
  end

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cur_r       <= '0;
      release_r   <= '0;
      len_r       <= '0;
      slave_r     <= 1'b0;
      disc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cue_fire || stat_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            func_r  <= in_func;
            tv_r    <= in_time_value;
            stop_r  <= in_cue_stop;
            frac_r  <= in_fraction;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          pcr_valid_r <= 1'b0;
          case (func_r)
            FN_LOAD: begin
              if (count_r < CNT_W'(CUE_DEPTH)) begin
                status_r <= ST_OK;
                count_r  <= count_r + 1'b1;
                if (stop_r > len_r) begin
                  len_r <= stop_r;
                end
              end else begin
                status_r <= ST_REJECT;
              end
              state_r <= S_STATUS;
            end
            FN_SEEK_T: begin
              status_r <= ST_OK;
              seek_t_r <= tv_r;
              lo_r     <= '0;
              hi_r     <= count_r;
              state_r  <= S_SRCH_RD;
            end
            FN_SEEK_POS: begin
              if (count_r == '0) begin
                status_r <= ST_REJECT;
                state_r  <= S_STATUS;
              end else begin
                status_r <= ST_OK;
                prod_r   <= PROD_W'(len_pos) * PROD_W'(frac_sat);
                state_r  <= S_SCALE;
              end
            end
            FN_TICK: begin
              barrier_r <= release_r;
              exam_r    <= '0;
              state_r   <= S_TICK_RD;
            end
            FN_SET_TIME: begin
              status_r  <= ST_OK;
              slave_r   <= 1'b1;
              release_r <= tv_r;
              state_r   <= S_STATUS;
            end
            default: begin
              status_r <= ST_REJECT;
              state_r  <= S_STATUS;
            end
          endcase
        end
        S_SCALE: begin
          seek_t_r <= TIME_W'(prod_r >> 16);
          lo_r     <= '0;
          hi_r     <= count_r;
          state_r  <= S_SRCH_RD;
        end
        // lower-bound search, a read state then a compare state per probe
        S_SRCH_RD: begin
          mid_r <= mid_nxt;
          if (lo_r < hi_r) begin
            state_r <= S_SRCH_CMP;
          end else begin
            state_r <= S_SEEK_RD;
          end
        end
        S_SRCH_CMP: begin
          if (rd_start < seek_t_r) begin
            lo_r <= mid_r + 1'b1;
          end else begin
            hi_r <= mid_r;
          end
          state_r <= S_SRCH_RD;
        end
        S_SEEK_RD: begin
          cur_r  <= lo_r;
          disc_r <= 1'b1;
          if (lo_r < count_r) begin
            state_r <= S_SEEK_SET;
          end else begin
            release_r <= seek_t_r;
            state_r   <= S_STATUS;
          end
        end
        S_SEEK_SET: begin
          release_r <= rd_start;
          state_r   <= S_STATUS;
        end
        // release loop, a read state then a check state per cue; a full output slot holds the check
        S_TICK_RD: begin
          state_r <= tick_more ? S_TICK_CHK : S_TICK_END;
        end
        S_TICK_CHK: begin
          if (rd_start > barrier_r) begin
            state_r <= S_TICK_END;
          end else if (rd_start[TIME_W-1]) begin
            // negative start: consumed silently
            cur_r   <= cur_r + 1'b1;
            exam_r  <= exam_r + 1'b1;
            state_r <= S_TICK_RD;
          end else if (slot_free) begin
            out_r   <= cue_item;
            disc_r  <= 1'b0;
            cur_r   <= cur_r + 1'b1;
            exam_r  <= exam_r + 1'b1;
            state_r <= S_TICK_RD;
          end
        end
        S_TICK_END: begin
          if (!slave_r) begin
            pcr_valid_r <= 1'b1;
            release_r   <= release_r + TIME_W'(tick_step);
          end
          status_r <= (cur_r >= count_r) ? ST_DONE : ST_OK;
          state_r  <= S_STATUS;
        end
        S_STATUS: begin
          if (slot_free) begin
            out_r   <= stat_item;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/timed_cue_release_scheduler.sv */
// Channel   Dir  Ports                                Handshake
// in_item   in   func, time_value, cue_stop, fraction valid/ready
// out_item  out  cue items, then one status item      valid/ready
// cfg_*     in   APB register tick_step at 0x0        psel/penable
//
// One item at a time. Load and set time go straight to the status item. Seek
// runs a lower-bound search, a read and a compare state per probe, through the
// single read port of the cue store. Tick reads and checks cues in turn, at
// most MAX_RELEASE, until a cue not yet due. Output stalls hold the sequencer.
// Synchronous active-low reset; the cue store is not cleared.
module timed_cue_release_scheduler #(
  parameter int unsigned CUE_DEPTH   = 1024,
  parameter int unsigned MAX_RELEASE = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  tcrs_in_if.sink                           in_item,
  tcrs_out_if.source                        out_item,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [tcrs_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [tcrs_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [tcrs_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import tcrs_pkg::*;

  localparam int unsigned IDX_W = $clog2(CUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(CUE_DEPTH + 1);

  logic [STEP_W-1:0]   tick_step;
  logic                mem_wr_en;
  logic [IDX_W-1:0]    mem_wr_addr;
  logic [2*TIME_W-1:0] mem_wr_data;
  logic                mem_rd_en;
  logic [IDX_W-1:0]    mem_rd_addr;
  logic [2*TIME_W-1:0] mem_rd_data;
  out_item_t           res;

  tcrs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .pready    (cfg_pready),
    .tick_step (tick_step)
  );

  tcrs_cue_mem #(.DEPTH(CUE_DEPTH), .AW(IDX_W)) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  tcrs_ctrl #(
    .CUE_DEPTH   (CUE_DEPTH),
    .MAX_RELEASE (MAX_RELEASE),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_item.valid),
    .in_ready      (in_item.ready),
    .in_func       (in_item.func),
    .in_time_value (in_item.time_value),
    .in_cue_stop   (in_item.cue_stop),
    .in_fraction   (in_item.fraction),
    .out_valid     (out_item.valid),
    .out_ready     (out_item.ready),
    .out_item      (res),
    .tick_step     (tick_step),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_en     (mem_rd_en),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data)
  );

  assign out_item.is_status     = res.is_status;
  assign out_item.cue_index     = res.cue_index;
  assign out_item.pts_or_pcr    = res.pts_or_pcr;
  assign out_item.duration      = res.duration;
  assign out_item.has_duration  = res.has_duration;
  assign out_item.continued     = res.continued;
  assign out_item.discontinuity = res.discontinuity;
  assign out_item.pcr_valid     = res.pcr_valid;
  assign out_item.next_time     = res.next_time;
  assign out_item.total_length  = res.total_length;
  assign out_item.status_code   = res.status_code;
  assign out_item.last          = res.last;

endmodule

/* rtl/tcrs_checker.sv */
module tcrs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            is_status,
  input logic                            last,
  input logic                            pcr_valid,
  input logic [tcrs_pkg::STAT_W-1:0]     status_code,
  input logic [tcrs_pkg::TIME_W-1:0]     pts_or_pcr
);
  import tcrs_pkg::*;

  // only a status item closes an input
  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last == is_status)) else $error("last without status");

  // cue items carry no status
  a_cue_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !is_status) |-> (status_code == ST_OK && !pcr_valid))
    else $error("cue item with status fields");

  // no clock reference, no pcr value
  a_pcr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && is_status && !pcr_valid) |-> (pts_or_pcr == '0))
    else $error("pcr value without pcr_valid");

  // an accepted item keeps the block busy next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("input taken while busy");

  // reset empties the output
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("output valid after reset");

endmodule

bind timed_cue_release_scheduler tcrs_checker u_tcrs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_item.valid),
  .in_ready    (in_item.ready),
  .out_valid   (out_item.valid),
  .is_status   (out_item.is_status),
  .last        (out_item.last),
  .pcr_valid   (out_item.pcr_valid),
  .status_code (out_item.status_code),
  .pts_or_pcr  (out_item.pts_or_pcr)
);

/* dv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tcrs_pkg::*;

  localparam int unsigned CUE_DEPTH    = 1024;
  localparam int unsigned MAX_RELEASE  = 32;
  localparam int unsigned CYCLE_LIMIT  = 4000000;
  localparam logic [CFG_ADDR_W-1:0] TICK_STEP_ADDR = CFG_ADDR_W'(4 * REG_TICK_STEP);
  localparam logic signed [TIME_W-1:0] T_MAX = {1'b0, {(TIME_W-1){1'b1}}};
  localparam logic signed [TIME_W-1:0] T_MIN = {1'b1, {(TIME_W-1){1'b0}}};

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  tcrs_in_if  in_if ();
  tcrs_out_if out_if ();

  timed_cue_release_scheduler #(
    .CUE_DEPTH  (CUE_DEPTH),
    .MAX_RELEASE(MAX_RELEASE)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_if),
    .out_item   (out_if),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // shadow of the scheduler state
  logic signed [TIME_W-1:0] cue_start [CUE_DEPTH];
  logic signed [TIME_W-1:0] cue_end   [CUE_DEPTH];
  int unsigned              n_cues;
  int unsigned              next_cue;
  logic signed [TIME_W-1:0] barrier_time;
  logic signed [TIME_W-1:0] longest_stop;
  logic                     follows_master;
  logic                     seek_marked;
  logic [STEP_W-1:0]        step_size;

  out_item_t release_q[$];
  int        n_errors;
  int        cycle_cnt;

  // idling control
  bit          no_idle;
  int unsigned ready_hold;
  int unsigned ready_burst;

  // cursor for ascending start times
  logic signed [TIME_W-1:0] start_cursor;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [TIME_W-1:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TIME_W-1:0];
  endfunction

  // lower-bound search, barrier moves to the hit or to the requested time
  task automatic seek_cues(logic signed [TIME_W-1:0] t);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = n_cues;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (cue_start[mid] < t) lo = mid + 1;
      else hi = mid;
    end
    next_cue = lo;
    barrier_time = (lo < n_cues) ? cue_start[lo] : t;
    seek_marked = 1'b1;
  endtask

  // work out the results one accepted item causes
  task automatic predict_scheduler(logic [FUNC_W-1:0] fn, logic signed [TIME_W-1:0] tv,
                                   logic signed [TIME_W-1:0] stp, logic [FRAC_W-1:0] fr);
    out_item_t r;
    logic signed [TIME_W-1:0] barrier, s, e, diff;
    logic [63:0] len, frac64;
    logic [STAT_W-1:0] status;
    logic signed [TIME_W-1:0] pcr;
    logic pv, hd;
    int examined;
    status = ST_OK;
    pcr = '0;
    pv = 1'b0;
    case (fn)
      FN_LOAD: begin
        if (n_cues < CUE_DEPTH) begin
          cue_start[n_cues] = tv;
          cue_end[n_cues] = stp;
          n_cues++;
          if (stp > longest_stop) longest_stop = stp;
        end else begin
          status = ST_REJECT;
        end
      end
      FN_SEEK_T: seek_cues(tv);
      FN_SEEK_POS: begin
        if (n_cues == 0) begin
          status = ST_REJECT;
        end else begin
          len = (longest_stop > 0) ? 64'(longest_stop) : 64'd0;
          frac64 = (fr > FRAC_FULL) ? 64'(FRAC_FULL) : 64'(fr);
          len = (len * frac64) >> 16;
          seek_cues(len[TIME_W-1:0]);
        end
      end
      FN_TICK: begin
        barrier = barrier_time;
        examined = 0;
        while (next_cue < n_cues && examined < MAX_RELEASE) begin
          s = cue_start[next_cue];
          e = cue_end[next_cue];
          if (s > barrier) break;
          if (s >= 0) begin
            hd = (e >= 0) && (e >= s);
            diff = e - s;
            r = '0;
            r.cue_index = next_cue[CIDX_W-1:0];
            r.pts_or_pcr = s;
            r.duration = hd ? diff[DUR_W-1:0] : '0;
            r.has_duration = hd;
            r.continued = (next_cue > 0);
            r.discontinuity = seek_marked;
            seek_marked = 1'b0;
            r.next_time = barrier_time;
            r.total_length = longest_stop;
            release_q.push_back(r);
          end
          next_cue++;
          examined++;
        end
        if (!follows_master) begin
          pcr = barrier;
          pv = 1'b1;
          barrier_time = barrier_time + TIME_W'(step_size);
        end
        status = (next_cue >= n_cues) ? ST_DONE : ST_OK;
      end
      FN_SET_TIME: begin
        follows_master = 1'b1;
        barrier_time = tv;
      end
      default: status = ST_REJECT;
    endcase
    r = '0;
    r.is_status = 1'b1;
    r.pts_or_pcr = pcr;
    r.pcr_valid = pv;
    r.next_time = barrier_time;
    r.total_length = longest_stop;
    r.status_code = status;
    r.last = 1'b1;
    release_q.push_back(r);
  endtask

  // send one item, with a random gap in front unless idling is off
  task automatic send_item(logic [FUNC_W-1:0] fn, logic signed [TIME_W-1:0] tv,
                           logic signed [TIME_W-1:0] stp, logic [FRAC_W-1:0] fr);
    int unsigned gap;
    gap = (!no_idle && $urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : 0;
    if (gap != 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.func = fn;
    in_if.time_value = tv;
    in_if.cue_stop = stp;
    in_if.fraction = fr;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_scheduler(fn, tv, stp, fr);
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (release_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  // register write then read-back, only while the block is idle
  task automatic write_tick_step(logic [STEP_W-1:0] v);
    wait_drained();
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = TICK_STEP_ADDR;
    cfg_pwdata = CFG_DATA_W'(v);
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    step_size = v;
    @(negedge clk);
    cfg_pwrite = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[STEP_W-1:0] !== v) begin
      $display("%0t tick_step read-back: expected %0d actual %0d", $time, v,
               cfg_prdata[STEP_W-1:0]);
      n_errors++;
    end
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // load with an ascending start, occasionally anything at all
  task automatic load_next_cue();
    logic signed [TIME_W-1:0] st, sp;
    if ($urandom_range(0, 9) == 0) begin
      st = rand48();
    end else begin
      start_cursor = start_cursor + TIME_W'($urandom_range(0, 90000));
      st = start_cursor;
    end
    case ($urandom_range(0, 5))
      0: sp = rand48();
      1: sp = -TIME_W'($urandom_range(1, 1000));
      2: sp = st - TIME_W'($urandom_range(1, 500));
      default: sp = st + TIME_W'($urandom_range(0, 400000));
    endcase
    send_item(FN_LOAD, st, sp, FRAC_W'(rand48()));
  endtask

  task automatic random_item(bit with_slave);
    int unsigned pick;
    logic signed [TIME_W-1:0] t;
    pick = $urandom_range(0, 99);
    t = ($urandom_range(0, 3) == 0) ? rand48() : start_cursor - TIME_W'($urandom_range(0, 600000));
    if (pick < 35) load_next_cue();
    else if (pick < 68) send_item(FN_TICK, rand48(), rand48(), FRAC_W'($urandom));
    else if (pick < 80) send_item(FN_SEEK_T, t, rand48(), FRAC_W'($urandom));
    else if (pick < 92) send_item(FN_SEEK_POS, rand48(), rand48(),
                                  ($urandom_range(0, 3) == 0) ? FRAC_W'($urandom)
                                                              : FRAC_W'($urandom_range(0, 65536)));
    else if (pick < 96 && with_slave) send_item(FN_SET_TIME, t, rand48(), FRAC_W'($urandom));
    else if (pick < 96) send_item(FN_TICK, rand48(), rand48(), FRAC_W'($urandom));
    else send_item(FUNC_W'($urandom_range(5, 7)), rand48(), rand48(), FRAC_W'($urandom));
  endtask

  // receiver: random stall bursts, long hold-off on request, none when quiet
  always @(negedge clk) begin
    if (ready_hold != 0) begin
      out_if.ready = 1'b0;
      ready_hold--;
    end else if (no_idle) begin
      out_if.ready = 1'b1;
    end else if (ready_burst != 0) begin
      out_if.ready = 1'b0;
      ready_burst--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_if.ready = 1'b0;
      ready_burst = $urandom_range(0, 15);
    end else begin
      out_if.ready = 1'b1;
    end
  end

  task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      $display("%0t %s: expected %0h actual %0h", $time, name, exp, act);
      n_errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (release_q.size() == 0) begin
        $display("%0t unexpected item: actual cue_index %0d is_status %0b", $time,
                 out_if.cue_index, out_if.is_status);
        n_errors++;
      end else begin
        e = release_q.pop_front();
        check_field("is_status", e.is_status, out_if.is_status);
        check_field("cue_index", e.cue_index, out_if.cue_index);
        check_field("pts_or_pcr", e.pts_or_pcr, out_if.pts_or_pcr);
        check_field("duration", e.duration, out_if.duration);
        check_field("has_duration", e.has_duration, out_if.has_duration);
        check_field("continued", e.continued, out_if.continued);
        check_field("discontinuity", e.discontinuity, out_if.discontinuity);
        check_field("pcr_valid", e.pcr_valid, out_if.pcr_valid);
        check_field("next_time", e.next_time, out_if.next_time);
        check_field("total_length", e.total_length, out_if.total_length);
        check_field("status_code", e.status_code, out_if.status_code);
        check_field("last", e.last, out_if.last);
      end
    end
  end

  // tick, position seek and time seek on an empty table, unknown codes
  task automatic test_empty_table();
    send_item(FN_TICK, '0, '0, '0);
    send_item(FN_SEEK_POS, '0, '0, FRAC_FULL);
    send_item(FN_SEEK_T, T_MAX, '0, '0);
    send_item(3'd5, T_MIN, T_MAX, '1);
    send_item(3'd6, '0, '0, '0);
    send_item(3'd7, T_MAX, T_MIN, '0);
    send_item(FN_SEEK_T, '0, '0, '0);
  endtask

  // more than the per-tick cap of cues all due at once
  task automatic test_release_cap();
    for (int i = 0; i < 34; i++) send_item(FN_LOAD, TIME_W'(i * 10), TIME_W'(i * 10 + 7), '0);
    send_item(FN_SEEK_T, '0, '0, '0);
    send_item(FN_TICK, '0, '0, '0);
    send_item(FN_TICK, '0, '0, '0);
    send_item(FN_TICK, '0, '0, '0);
  endtask

  // negative start, missing stop, duplicates, stop before start, extremes
  task automatic test_cue_extremes();
    send_item(FN_LOAD, 400, -1, '0);
    send_item(FN_LOAD, 400, T_MIN, '0);
    send_item(FN_SEEK_T, 400, '0, '0);
    send_item(FN_SEEK_T, 5000, '0, '0);
    send_item(FN_LOAD, T_MIN, 600, '0);
    send_item(FN_LOAD, 600, 10, '0);
    send_item(FN_LOAD, T_MAX, T_MAX, '0);
    send_item(FN_SEEK_POS, '0, '0, '0);
    send_item(FN_SEEK_POS, '0, '0, FRAC_FULL);
    send_item(FN_SEEK_POS, '0, '0, '1);
    send_item(FN_SEEK_T, 300, '0, '0);
    send_item(FN_TICK, '0, '0, '0);
    send_item(FN_TICK, '0, '0, '0);
    start_cursor = 1000;
  endtask

  // master-mode random runs at several step sizes, barrier wrap included
  task automatic test_master_steps();
    logic [STEP_W-1:0] steps [4];
    steps = '{STEP_W'(1), '1, STEP_W'(200000), TICK_STEP_RST};
    foreach (steps[k]) begin
      write_tick_step(steps[k]);
      send_item(FN_SEEK_T, start_cursor, '0, '0);
      for (int i = 0; i < 30; i++) random_item(1'b0);
    end
    wait_drained();
    send_item(FN_SEEK_T, T_MAX, '0, '0);
    write_tick_step('1);
    send_item(FN_TICK, '0, '0, '0);
    send_item(FN_TICK, '0, '0, '0);
    write_tick_step(STEP_W'(100000));
    send_item(FN_SEEK_T, start_cursor - 300000, '0, '0);
  endtask

  // set time switches to slave mode for good
  task automatic test_slave_mode();
    send_item(FN_SET_TIME, start_cursor - 200000, '0, '0);
    send_item(FN_TICK, '0, '0, '0);
    send_item(FN_SET_TIME, start_cursor, '0, '0);
    send_item(FN_TICK, '0, '0, '0);
    for (int i = 0; i < 100; i++) random_item(1'b1);
  endtask

  // receiver holds off while the sender keeps offering, then a full drain
  task automatic test_backpressure();
    wait_drained();
    ready_hold = 500;
    send_item(FN_SEEK_T, start_cursor - 500000, '0, '0);
    for (int i = 0; i < 30; i++) begin
      send_item(FN_SET_TIME, start_cursor, '0, '0);
      send_item(FN_TICK, '0, '0, '0);
      load_next_cue();
    end
    wait_drained();
    for (int i = 0; i < 20; i++) random_item(1'b1);
  endtask

  // closing stretch with no idling on either side
  task automatic test_quiet_tail();
    wait_drained();
    no_idle = 1'b1;
    send_item(FN_SEEK_POS, '0, '0, 17'h08000);
    send_item(FN_SEEK_T, start_cursor + 1, '0, '0);
    for (int i = 0; i < 40; i++) random_item(1'b1);
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.func = FN_LOAD;
    in_if.time_value = '0;
    in_if.cue_stop = '0;
    in_if.fraction = '0;
    out_if.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    n_errors = 0;
    cycle_cnt = 0;
    no_idle = 1'b0;
    ready_hold = 0;
    ready_burst = 0;
    n_cues = 0;
    next_cue = 0;
    barrier_time = '0;
    longest_stop = '0;
    follows_master = 1'b0;
    seek_marked = 1'b0;
    step_size = TICK_STEP_RST;
    start_cursor = 400;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_table();
    test_release_cap();
    test_cue_extremes();
    test_master_steps();
    test_slave_mode();
    test_backpressure();
    test_quiet_tail();

    while (release_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
